>>> rtl/cave_pkg.sv
// ----------------------------------------------------------------------------
// cave_pkg
// Shared constants and types for the cave automaton step core.
// ----------------------------------------------------------------------------
package cave_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 13;
  localparam int GW_W   = 9;
  localparam int GH_W   = 13;
  localparam int MIN_DIM = 3;

  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 9'd200;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 13'd200;

  localparam logic [3:0] CAVE_THRESH   = 4'd4;
  localparam logic [3:0] SMOOTH_THRESH = 4'd5;

  typedef enum logic [CFG_IW-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_RULE_MODE   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  typedef enum logic {
    RULE_CAVE   = 1'b0,
    RULE_SMOOTH = 1'b1
  } rule_t;

  typedef struct packed {
    logic cell_bit;
    logic last;
  } result_t;

endpackage

>>> rtl/cave_automaton_step_core.sv
// ----------------------------------------------------------------------------
// cave_automaton_step_core
// One generation of a binary cave automaton over a raster-streamed grid.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_ready is high: a push carries the next
// raster cell, a drain (after the last cell of the frame) flushes one pending
// cell. Each cell is emitted W+1 effective requests after it arrived, once its
// 3x3 neighbourhood is in the window; the result is registered into the output
// stage. Two one-bit line stores of MAX_WIDTH entries, read one column
// ahead with registered data, feed the right-hand column of the window, so the
// store port never limits the rate. A two-slot output stage keeps in_ready
// high while one result waits; it drops only when both slots are full.
// Configuration writes abandon the frame in progress; width and height are
// clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT].
// ----------------------------------------------------------------------------
module cave_automaton_step_core #(
  parameter int MAX_WIDTH  = cave_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cave_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic                        cell_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        cell_out,
  output logic                        frame_last,
  input  logic                        cfg_we,
  input  logic [cave_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cave_pkg::CFG_DW-1:0] cfg_data
);
  import cave_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [GW_W-1:0] grid_width;
  logic [GH_W-1:0] grid_height;
  logic            rule_mode;
  logic            cfg_hit;

  logic [31:0]   gw_ext, gh_ext, w_eff, h_eff;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  // position state
  logic [CW-1:0] pcol, pcol_next;
  logic [RW-1:0] prow, prow_next;
  logic [1:0]    rows_seen, rows_seen_next;
  logic          frame_in, frame_in_next;
  logic [CW-1:0] ecol, ecol_next;
  logic [RW-1:0] erow, erow_next;

  // line stores and window
  logic          line1_mem [MAX_WIDTH];
  logic          line2_mem [MAX_WIDTH];
  logic          rd1, rd2;
  logic [1:0]    top_win, mid_win, bot_win;

  logic accept, is_drain, shift, emit, frame_done;
  logic l_in, r_in, t_in, b_in;
  logic [7:0] nb;
  logic [3:0] cnt8, cnt9;
  result_t    res;

  // output stage
  result_t main_q, skid_q;
  logic    main_v, skid_v, pop;

  assign cfg_hit = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT ||
                              cfg_index == REG_RULE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      rule_mode   <= RULE_CAVE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GH_W-1:0];
        REG_RULE_MODE:   rule_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gw_ext = 32'(grid_width);
    gh_ext = 32'(grid_height);
    if (gw_ext < 32'(MIN_DIM))        w_eff = 32'(MIN_DIM);
    else if (gw_ext > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    else                              w_eff = gw_ext;
    if (gh_ext < 32'(MIN_DIM))         h_eff = 32'(MIN_DIM);
    else if (gh_ext > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
    else                               h_eff = gh_ext;
  end

  assign w_last = CW'(w_eff - 32'd1);
  assign h_last = RW'(h_eff - 32'd1);

  assign accept     = in_valid && in_ready;
  assign is_drain   = (func == FUNC_DRAIN);
  assign shift      = accept && (is_drain ? frame_in : !frame_in);
  assign emit       = shift && ((rows_seen == 2'd2) || (rows_seen == 2'd1 && pcol != '0));
  assign frame_done = emit && (ecol == w_last) && (erow == h_last);

  always_comb begin
    pcol_next      = pcol;
    prow_next      = prow;
    rows_seen_next = rows_seen;
    frame_in_next  = frame_in;
    ecol_next      = ecol;
    erow_next      = erow;
    priority if (cfg_hit || frame_done) begin
      pcol_next      = '0;
      prow_next      = '0;
      rows_seen_next = 2'd0;
      frame_in_next  = 1'b0;
      ecol_next      = '0;
      erow_next      = '0;
    end else if (shift) begin
      if (pcol == w_last) begin
        pcol_next = '0;
        if (rows_seen != 2'd2) rows_seen_next = rows_seen + 2'd1;
        if (!is_drain) begin
          if (prow == h_last) begin
            prow_next     = '0;
            frame_in_next = 1'b1;
          end else begin
            prow_next = prow + RW'(1);
          end
        end
      end else begin
        pcol_next = pcol + CW'(1);
      end
      if (emit) begin
        if (ecol == w_last) begin
          ecol_next = '0;
          erow_next = erow + RW'(1);
        end else begin
          ecol_next = ecol + CW'(1);
        end
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcol      <= '0;
      prow      <= '0;
      rows_seen <= 2'd0;
      frame_in  <= 1'b0;
      ecol      <= '0;
      erow      <= '0;
    end else begin
      pcol      <= pcol_next;
      prow      <= prow_next;
      rows_seen <= rows_seen_next;
      frame_in  <= frame_in_next;
      ecol      <= ecol_next;
      erow      <= erow_next;
    end
  end

  // line stores: read one column ahead, write the column being shifted
  always_ff @(posedge clk) begin
    if (shift) line1_mem[pcol] <= cell_req;
    rd1 <= line1_mem[pcol_next];
  end

  always_ff @(posedge clk) begin
    if (shift) line2_mem[pcol] <= rd1;
    rd2 <= line2_mem[pcol_next];
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      top_win <= {top_win[0], rd2};
      mid_win <= {mid_win[0], rd1};
      bot_win <= {bot_win[0], cell_req};
    end
  end

  // neighbourhood of the emitted cell; outside cells read as walls
  assign l_in = (ecol != '0);
  assign r_in = (ecol != w_last);
  assign t_in = (erow != '0);
  assign b_in = (erow != h_last);

  assign nb = {top_win[1] | ~(t_in & l_in), top_win[0] | ~t_in, rd2 | ~(t_in & r_in),
               mid_win[1] | ~l_in,                               rd1 | ~r_in,
               bot_win[1] | ~(b_in & l_in), bot_win[0] | ~b_in, cell_req | ~(b_in & r_in)};

  assign cnt8 = 4'($countones(nb));
  assign cnt9 = 4'($countones({top_win, rd2, mid_win, rd1, bot_win, cell_req}));

  always_comb begin
    res.last = frame_done;
    if (rule_mode == RULE_CAVE) begin
      if (cnt8 > CAVE_THRESH)      res.cell_bit = 1'b1;
      else if (cnt8 < CAVE_THRESH) res.cell_bit = 1'b0;
      else                         res.cell_bit = mid_win[0];
    end else begin
      if (!(l_in && r_in && t_in && b_in)) res.cell_bit = mid_win[0];
      else                                 res.cell_bit = (cnt9 >= SMOOTH_THRESH);
    end
  end

  // two-slot output stage
  assign pop       = main_v && out_ready;
  assign in_ready  = !skid_v;
  assign out_valid = main_v;
  assign cell_out  = main_q.cell_bit;
  assign frame_last = main_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        main_q <= skid_q;
        skid_v <= 1'b0;
      end
    end else if (emit) begin
      if (!main_v || pop) begin
        main_q <= res;
        main_v <= 1'b1;
      end else begin
        skid_q <= res;
        skid_v <= 1'b1;
      end
    end else if (pop) begin
      main_v <= 1'b0;
    end
  end

endmodule

>>> rtl/cave_chk.sv
// ----------------------------------------------------------------------------
// cave_chk
// Port-level checks for the cave automaton step core, bound to the top level.
// ----------------------------------------------------------------------------
module cave_chk (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cell_out,
  input logic frame_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_out) && $stable(frame_last))
    else $error("stalled result changed");

  // reset empties both output slots
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output stage not empty after reset");

  // back-pressure only with a result on show
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // second slot fills only behind a stalled result
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("in_ready dropped without output stall");

endmodule

bind cave_automaton_step_core cave_chk u_cave_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cell_out   (cell_out),
  .frame_last (frame_last)
);
